// ===== hdl/tcpu_pkg.sv =====
// Shared types, constants and helpers of the toy CPU decode and execute block.
package tcpu_pkg;

	localparam int DEF_DATA_WORDS = 256;
	localparam int DEF_REG_COUNT = 10;

	// Depth of the queue between decode and execute, and of the result queue.
	localparam int MQ_DEPTH = 2;
	localparam int OQ_DEPTH = 2;
	localparam int OQ_CW = $clog2(OQ_DEPTH + 1);

	localparam logic [31:0] HALT_PC = 32'd256;

	typedef enum logic [3:0] {
		K_NOP   = 4'd0,
		K_ADD   = 4'd1,
		K_CMP   = 4'd2,
		K_SUB   = 4'd3,
		K_JMP   = 4'd4,
		K_JMPT  = 4'd5,
		K_JMPF  = 4'd6,
		K_LOAD  = 4'd7,
		K_STORE = 4'd8
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [3:0]  ra;
		logic [3:0]  rb;
		logic [3:0]  rd;
		logic [7:0]  addr;
	} dec_t;

	typedef struct packed {
		logic [31:0] next_pc;
		logic        halted;
		logic        compare_flag;
	} res_t;

	typedef struct packed {
		logic [OQ_CW-1:0] count;
		logic             pop;
	} oq_stat_t;

	// Contents of the data store after reset.
	function automatic logic [31:0] dmem_init(input logic [7:0] addr);
		logic [31:0] v;
		v = 32'd0;
		if (addr == 8'd0)
			v = 32'd1;
		else if (addr == 8'd1)
			v = 32'd2;
		return v;
	endfunction

endpackage

// ===== hdl/toy_cpu_decode_execute.sv =====
// Top level of the toy CPU decode and execute block.
// Instructions enter through a queue interface (push/full) and one result per
// instruction leaves through another (empty/pop). One instruction is accepted
// and retired per clock cycle when the consumer keeps popping; an accepted
// instruction waits in the decode queue until it is issued into the execute
// second stage, and its result is then written into the result queue. Decode feeds
// a two-entry queue; execute reads the register file and the data store in its
// first stage through registered read ports, with a bypass from the instruction
// retiring in the same cycle, and updates all state in its second stage, which
// also sets the one-instruction-per-cycle limit through the flag and program
// counter loop. The data store comes out of reset at once with its initial
// words through per-word valid bits; there is no clearing pass.
module toy_cpu_decode_execute import tcpu_pkg::*; #(
	parameter int DATA_WORDS = DEF_DATA_WORDS,
	parameter int REG_COUNT  = DEF_REG_COUNT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [17:0] instruction_word,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] next_pc,
	output logic        halted,
	output logic        compare_flag
);

	logic     mid_valid;
	dec_t     mid_head;
	logic     mid_pop;
	oq_stat_t oq_stat;
	logic     res_push;
	res_t     res;
	res_t     oq_head;

	tcpu_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.instruction_word (instruction_word),
		.head_valid       (mid_valid),
		.head             (mid_head),
		.head_pop         (mid_pop)
	);

	tcpu_exec #(
		.DATA_WORDS (DATA_WORDS),
		.REG_COUNT  (REG_COUNT)
	) u_exec (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (mid_valid),
		.head       (mid_head),
		.head_pop   (mid_pop),
		.oq_stat    (oq_stat),
		.res_push   (res_push),
		.res        (res)
	);

	tcpu_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res      (res),
		.pop      (pop),
		.empty    (empty),
		.head     (oq_head),
		.stat     (oq_stat)
	);

	assign next_pc      = oq_head.next_pc;
	assign halted       = oq_head.halted;
	assign compare_flag = oq_head.compare_flag;

`ifndef NO_ASSERTIONS
	// An issued item always retires in the next cycle.
	a_issue_retires: assert property (@(posedge clk) disable iff (!arst_n)
		mid_pop |=> res_push)
		else $error("issued item did not retire");

	// The issue check must keep the result queue from overflowing.
	a_oq_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (oq_stat.count < OQ_CW'(OQ_DEPTH)))
		else $error("result queue overflow");

	// The halt mark follows the program counter of the shown item.
	a_halt_mark: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (halted == (next_pc >= HALT_PC)))
		else $error("halt mark inconsistent with next pc");
`endif

endmodule

// ===== hdl/tcpu_front.sv =====
// Front end: accepts instruction items, classifies them and queues them for execute.
module tcpu_front import tcpu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [17:0] instruction_word,
	output logic        head_valid,
	output dec_t        head,
	input  logic        head_pop
);

	localparam int MQ_AW = $clog2(MQ_DEPTH);
	localparam int MQ_CW = $clog2(MQ_DEPTH + 1);

	localparam logic [5:0] OP_ADD   = 6'd1;
	localparam logic [5:0] OP_CMP   = 6'd2;
	localparam logic [5:0] OP_SUB   = 6'd3;
	localparam logic [5:0] OP_JMP   = 6'd4;
	localparam logic [5:0] OP_JMPT  = 6'd5;
	localparam logic [5:0] OP_JMPF  = 6'd6;
	localparam logic [5:0] OP_LOAD  = 6'd8;
	localparam logic [5:0] OP_STORE = 6'd9;

	dec_t             ent_q [MQ_DEPTH];
	logic [MQ_AW-1:0] wptr_q;
	logic [MQ_AW-1:0] rptr_q;
	logic [MQ_CW-1:0] cnt_q;
	dec_t             dec;
	logic             wr;
	logic             rd;

	always_comb begin
		dec.ra   = instruction_word[11:8];
		dec.rb   = instruction_word[7:4];
		dec.rd   = instruction_word[3:0];
		dec.addr = instruction_word[7:0];
		case (instruction_word[17:12])
			OP_ADD:   dec.kind = K_ADD;
			OP_CMP:   dec.kind = K_CMP;
			OP_SUB:   dec.kind = K_SUB;
			OP_JMP:   dec.kind = K_JMP;
			OP_JMPT:  dec.kind = K_JMPT;
			OP_JMPF:  dec.kind = K_JMPF;
			OP_LOAD:  dec.kind = K_LOAD;
			OP_STORE: dec.kind = K_STORE;
			default:  dec.kind = K_NOP;
		endcase
		// A load writes the register named in the upper nibble.
		if (dec.kind == K_LOAD)
			dec.rd = instruction_word[11:8];
	end

	assign full = (cnt_q == MQ_CW'(MQ_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head = ent_q[rptr_q];
	assign wr = push && !full;
	assign rd = head_pop && head_valid;

	always_ff @(posedge clk) begin
		if (wr)
			ent_q[wptr_q] <= dec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr)
				wptr_q <= (wptr_q == MQ_AW'(MQ_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (rd)
				rptr_q <= (rptr_q == MQ_AW'(MQ_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			if (wr && !rd)
				cnt_q <= cnt_q + 1'b1;
			else if (rd && !wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== hdl/tcpu_exec.sv =====
// Back end: register file, data store, flag and program counter; two-stage execute.
module tcpu_exec import tcpu_pkg::*; #(
	parameter int DATA_WORDS = DEF_DATA_WORDS,
	parameter int REG_COUNT  = DEF_REG_COUNT
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     head_valid,
	input  dec_t     head,
	output logic     head_pop,
	input  oq_stat_t oq_stat,
	output logic     res_push,
	output res_t     res
);

	localparam int AW = $clog2(DATA_WORDS);
	localparam int RW = $clog2(REG_COUNT);

	logic [31:0]           regs_q [REG_COUNT];
	logic [31:0]           mem_q [DATA_WORDS];
	logic [DATA_WORDS-1:0] mvld_q;
	logic                  flag_q;
	logic [31:0]           pc_q;

	logic        valid_s2;
	dec_t        item_s2;
	logic [31:0] rda_s2;
	logic [31:0] rdb_s2;
	logic [31:0] mrd_s2;
	logic        mvld_s2;
	logic        mfwd_s2;
	logic [31:0] mfwdv_s2;
	logic        mrng_s2;

	logic [OQ_CW:0] occ;
	logic [31:0]    rda_n;
	logic [31:0]    rdb_n;
	logic           ra_ok;
	logic           rb_ok;
	logic           head_rng;
	logic [AW-1:0]  aidx;

	logic          rf_we;
	logic [3:0]    rf_widx;
	logic [31:0]   rf_wdata;
	logic          st_en;
	logic [AW-1:0] st_idx;
	logic [31:0]   mdata;
	logic          eq;
	logic [31:0]   pc_inc;
	logic [31:0]   pc_n;
	logic          flag_n;

	// Issue only when the result queue is sure to have room when this item
	// reaches the second stage.
	assign occ = {1'b0, oq_stat.count} + (OQ_CW + 1)'(valid_s2) - (OQ_CW + 1)'(oq_stat.pop);
	assign head_pop = head_valid && (occ < (OQ_CW + 1)'(OQ_DEPTH));

	assign aidx = head.addr[AW-1:0];
	assign head_rng = ({1'b0, head.addr} < 9'(DATA_WORDS));

	// Register reads happen at issue; a write retiring in the same cycle is bypassed.
	always_comb begin
		ra_ok = ({1'b0, head.ra} < 5'(REG_COUNT));
		rb_ok = ({1'b0, head.rb} < 5'(REG_COUNT));
		if (!ra_ok)
			rda_n = '0;
		else if (rf_we && rf_widx == head.ra)
			rda_n = rf_wdata;
		else
			rda_n = regs_q[head.ra[RW-1:0]];
		if (!rb_ok)
			rdb_n = '0;
		else if (rf_we && rf_widx == head.rb)
			rdb_n = rf_wdata;
		else
			rdb_n = regs_q[head.rb[RW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (head_pop) begin
			item_s2  <= head;
			rda_s2   <= rda_n;
			rdb_s2   <= rdb_n;
			mvld_s2  <= mvld_q[aidx];
			mfwd_s2  <= st_en && (st_idx == aidx);
			mfwdv_s2 <= rda_s2;
			mrng_s2  <= head_rng;
		end
	end

	always_ff @(posedge clk) begin
		if (st_en)
			mem_q[st_idx] <= rda_s2;
		if (head_pop)
			mrd_s2 <= mem_q[aidx];
	end

	// Second stage: everything that changes state retires here.
	always_comb begin
		if (!mrng_s2)
			mdata = '0;
		else if (mfwd_s2)
			mdata = mfwdv_s2;
		else if (mvld_s2)
			mdata = mrd_s2;
		else
			mdata = dmem_init(item_s2.addr);

		eq       = (rda_s2 == rdb_s2);
		pc_inc   = pc_q + 32'd1;
		pc_n     = pc_inc;
		flag_n   = flag_q;
		rf_wdata = mdata;
		rf_widx  = item_s2.rd;
		rf_we    = 1'b0;
		st_en    = 1'b0;
		st_idx   = item_s2.addr[AW-1:0];
		case (item_s2.kind)
			K_ADD: begin
				rf_we    = 1'b1;
				rf_wdata = rda_s2 + rdb_s2;
			end
			K_SUB: begin
				rf_we    = 1'b1;
				rf_wdata = rda_s2 - rdb_s2;
			end
			K_CMP:   flag_n = eq;
			K_JMP:   pc_n = mdata;
			K_JMPT:  pc_n = flag_q ? mdata : pc_inc;
			K_JMPF:  pc_n = flag_q ? pc_inc : mdata;
			K_LOAD:  rf_we = 1'b1;
			K_STORE: st_en = mrng_s2;
			default: ;
		endcase
		rf_we = rf_we && valid_s2 && ({1'b0, rf_widx} < 5'(REG_COUNT));
		st_en = st_en && valid_s2;
	end

	assign res_push = valid_s2;
	assign res.next_pc = pc_n;
	assign res.halted = (pc_n >= HALT_PC);
	assign res.compare_flag = flag_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			flag_q   <= 1'b0;
			pc_q     <= '0;
			mvld_q   <= '0;
			for (int i = 0; i < REG_COUNT; i++)
				regs_q[i] <= '0;
		end else begin
			valid_s2 <= head_pop;
			if (valid_s2) begin
				flag_q <= flag_n;
				pc_q   <= pc_n;
			end
			if (rf_we)
				regs_q[rf_widx[RW-1:0]] <= rf_wdata;
			if (st_en)
				mvld_q[st_idx] <= 1'b1;
		end
	end

endmodule

// ===== hdl/tcpu_outq.sv =====
// Result queue that holds finished items until the consumer pops them.
module tcpu_outq import tcpu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     res_push,
	input  res_t     res,
	input  logic     pop,
	output logic     empty,
	output res_t     head,
	output oq_stat_t stat
);

	localparam int OQ_AW = $clog2(OQ_DEPTH);

	res_t             ent_q [OQ_DEPTH];
	logic [OQ_AW-1:0] wptr_q;
	logic [OQ_AW-1:0] rptr_q;
	logic [OQ_CW-1:0] cnt_q;
	logic             rd;

	assign empty = (cnt_q == '0);
	assign head = ent_q[rptr_q];
	assign rd = pop && !empty;
	assign stat.count = cnt_q;
	assign stat.pop = rd;

	always_ff @(posedge clk) begin
		if (res_push)
			ent_q[wptr_q] <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (res_push)
				wptr_q <= (wptr_q == OQ_AW'(OQ_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (rd)
				rptr_q <= (rptr_q == OQ_AW'(OQ_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			if (res_push && !rd)
				cnt_q <= cnt_q + 1'b1;
			else if (rd && !res_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== dv/tcpu_exec_checker.sv =====
`timescale 1ns / 100ps
// Opcode names shared by the testbench files, and the checker that predicts and compares results.
package tcpu_tb_pkg;

	typedef enum logic [5:0] {
		OP_NOP   = 6'd0,
		OP_ADD   = 6'd1,
		OP_CMP   = 6'd2,
		OP_SUB   = 6'd3,
		OP_JMP   = 6'd4,
		OP_JMPT  = 6'd5,
		OP_JMPF  = 6'd6,
		OP_RSV7  = 6'd7,
		OP_LOAD  = 6'd8,
		OP_STORE = 6'd9,
		OP_RSV63 = 6'd63
	} opcode_t;

endpackage

module tcpu_exec_checker import tcpu_pkg::*; import tcpu_tb_pkg::*; #(
	parameter int DATA_WORDS = DEF_DATA_WORDS,
	parameter int REG_COUNT  = DEF_REG_COUNT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [17:0] instruction_word,
	input  logic        empty,
	input  logic        pop,
	input  logic [31:0] next_pc,
	input  logic        halted,
	input  logic        compare_flag,
	output int          mismatches,
	output int          outstanding,
	output int          checked,
	output int          halt_count,
	output int          jumps_taken
);

	localparam int MAX_REPORTS = 10;

	logic [31:0] gpr [16];
	logic [31:0] dmem [DATA_WORDS];
	logic        eq_flag;
	logic [31:0] pc;
	res_t        retire_q [$];
	int          fail_n;
	int          check_n;
	int          halt_n;
	int          taken_n;

	function automatic logic [31:0] gpr_read(input logic [3:0] idx);
		return (idx < REG_COUNT) ? gpr[idx] : 32'd0;
	endfunction

	// Executes one instruction against the shadow state and returns what must retire.
	function automatic res_t execute_instr(input logic [17:0] w);
		logic [3:0]  fa;
		logic [3:0]  fb;
		logic [3:0]  fd;
		logic [7:0]  addr;
		logic [31:0] target;
		res_t        r;
		fa = w[11:8];
		fb = w[7:4];
		fd = w[3:0];
		addr = w[7:0];
		target = (addr < DATA_WORDS) ? dmem[addr] : 32'd0;
		pc = pc + 32'd1;
		case (w[17:12])
			OP_ADD: begin
				if (fd < REG_COUNT)
					gpr[fd] = gpr_read(fa) + gpr_read(fb);
			end
			OP_SUB: begin
				if (fd < REG_COUNT)
					gpr[fd] = gpr_read(fa) - gpr_read(fb);
			end
			OP_CMP: begin
				eq_flag = (gpr_read(fa) == gpr_read(fb));
			end
			OP_JMP: begin
				pc = target;
				taken_n++;
			end
			OP_JMPT: begin
				if (eq_flag) begin
					pc = target;
					taken_n++;
				end
			end
			OP_JMPF: begin
				if (!eq_flag) begin
					pc = target;
					taken_n++;
				end
			end
			OP_LOAD: begin
				if (fa < REG_COUNT)
					gpr[fa] = target;
			end
			OP_STORE: begin
				if (addr < DATA_WORDS)
					dmem[addr] = gpr_read(fa);
			end
			default: begin
			end
		endcase
		r.next_pc = pc;
		r.halted = (pc >= HALT_PC);
		r.compare_flag = eq_flag;
		if (r.halted)
			halt_n++;
		return r;
	endfunction

	task automatic check_result();
		res_t want;
		if (retire_q.size() == 0) begin
			fail_n++;
			if (fail_n <= MAX_REPORTS)
				$display("ERROR %0t: unexpected result next_pc=%h halted=%b flag=%b",
					$time, next_pc, halted, compare_flag);
		end else begin
			want = retire_q.pop_front();
			check_n++;
			if (next_pc !== want.next_pc || halted !== want.halted ||
					compare_flag !== want.compare_flag) begin
				fail_n++;
				if (fail_n <= MAX_REPORTS)
					$display("ERROR %0t: result %0d expected pc=%h halt=%b flag=%b, got pc=%h halt=%b flag=%b",
						$time, check_n, want.next_pc, want.halted, want.compare_flag,
						next_pc, halted, compare_flag);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++)
				gpr[i] = 32'd0;
			for (int i = 0; i < DATA_WORDS; i++)
				dmem[i] = 32'd0;
			dmem[0] = 32'd1;
			if (DATA_WORDS > 1)
				dmem[1] = 32'd2;
			eq_flag = 1'b0;
			pc = 32'd0;
			retire_q.delete();
			fail_n = 0;
			check_n = 0;
			halt_n = 0;
			taken_n = 0;
		end else begin
			if (pop && !empty)
				check_result();
			if (push && !full)
				retire_q.push_back(execute_instr(instruction_word));
		end
		// Outputs move after the edge so the top never races the update.
		mismatches <= fail_n;
		outstanding <= retire_q.size();
		checked <= check_n;
		halt_count <= halt_n;
		jumps_taken <= taken_n;
	end

endmodule

// ===== dv/toy_cpu_decode_execute_tb.sv =====
`timescale 1ns / 100ps
// Testbench top: clock, reset, instruction stimulus, result draining and the verdict.
module toy_cpu_decode_execute_tb;
	import tcpu_pkg::*;
	import tcpu_tb_pkg::*;

	localparam int RANDOM_ITEMS = 1400;
	localparam int CALM_TAIL    = 150;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [17:0] instruction_word;
	logic        empty;
	logic        pop;
	logic [31:0] next_pc;
	logic        halted;
	logic        compare_flag;

	int mismatches;
	int outstanding;
	int checked;
	int halt_count;
	int jumps_taken;
	int issued;
	bit calm;
	bit quiet_tx;

	toy_cpu_decode_execute u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.instruction_word (instruction_word),
		.empty            (empty),
		.pop              (pop),
		.next_pc          (next_pc),
		.halted           (halted),
		.compare_flag     (compare_flag)
	);

	tcpu_exec_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.instruction_word (instruction_word),
		.empty            (empty),
		.pop              (pop),
		.next_pc          (next_pc),
		.halted           (halted),
		.compare_flag     (compare_flag),
		.mismatches       (mismatches),
		.outstanding      (outstanding),
		.checked          (checked),
		.halt_count       (halt_count),
		.jumps_taken      (jumps_taken)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic logic [17:0] enc_rrr(input opcode_t op, input logic [3:0] a,
			input logic [3:0] b, input logic [3:0] d);
		return {op, a, b, d};
	endfunction

	function automatic logic [17:0] enc_mem(input opcode_t op, input logic [3:0] r,
			input logic [7:0] addr);
		return {op, r, addr};
	endfunction

	// Mostly real registers, now and then any index, which may be one that reads as zero.
	function automatic logic [3:0] gpr_pick();
		if ($urandom_range(0, 7) == 0)
			return 4'($urandom);
		return 4'($urandom_range(0, DEF_REG_COUNT - 1));
	endfunction

	// A small address window keeps stores and later loads or jumps meeting often.
	function automatic logic [7:0] addr_pick();
		if ($urandom_range(0, 3) == 0)
			return 8'($urandom);
		return 8'($urandom_range(0, 15));
	endfunction

	function automatic logic [17:0] rand_instr();
		int         sel;
		logic [5:0] op;
		sel = $urandom_range(0, 99);
		if (sel < 18)
			op = OP_ADD;
		else if (sel < 30)
			op = OP_SUB;
		else if (sel < 40)
			op = OP_CMP;
		else if (sel < 46)
			op = OP_JMP;
		else if (sel < 51)
			op = OP_JMPT;
		else if (sel < 56)
			op = OP_JMPF;
		else if (sel < 70)
			op = OP_LOAD;
		else if (sel < 84)
			op = OP_STORE;
		else
			op = 6'($urandom);
		if (op == OP_ADD || op == OP_SUB || op == OP_CMP)
			return {op, gpr_pick(), gpr_pick(), gpr_pick()};
		return {op, gpr_pick(), addr_pick()};
	endfunction

	task automatic idle_burst(input int n);
		repeat (n) begin
			@(negedge clk);
			push <= 1'b0;
			instruction_word <= 18'($urandom);
		end
	endtask

	task automatic send(input logic [17:0] w);
		if (!calm && !quiet_tx && $urandom_range(0, 6) == 0)
			idle_burst($urandom_range(1, 18));
		@(negedge clk);
		push <= 1'b1;
		instruction_word <= w;
		do
			@(posedge clk);
		while (full);
		issued++;
	endtask

	// Result side: random stall bursts, quiet stretches, and none in the tail.
	initial begin
		int  hold;
		int  cyc;
		bit  quiet_rx;
		hold = 0;
		cyc = 0;
		quiet_rx = 1'b0;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc % 128 == 0)
				quiet_rx = ($urandom_range(0, 3) == 0);
			if (hold > 0) begin
				hold--;
				pop <= 1'b0;
			end else if (!calm && !quiet_rx && $urandom_range(0, 7) == 0) begin
				hold = $urandom_range(0, 17);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin
		int          sent_rand;
		int          pick;
		logic [7:0]  a;
		arst_n = 1'b0;
		push = 1'b0;
		instruction_word = 18'd0;
		issued = 0;
		calm = 1'b0;
		quiet_tx = 1'b0;
		sent_rand = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		send(enc_mem(OP_LOAD, 4'd0, 8'd0));
		send(enc_mem(OP_LOAD, 4'd1, 8'd1));
		send(enc_rrr(OP_ADD, 4'd0, 4'd1, 4'd2));
		send(enc_rrr(OP_SUB, 4'd0, 4'd1, 4'd3));
		// Sum wraps around 2^32.
		send(enc_rrr(OP_ADD, 4'd3, 4'd3, 4'd4));
		send(enc_rrr(OP_CMP, 4'd0, 4'd1, 4'd0));
		send(enc_mem(OP_JMPT, 4'd0, 8'd1));
		send(enc_mem(OP_JMPF, 4'd0, 8'd1));
		send(enc_rrr(OP_CMP, 4'd5, 4'd6, 4'd0));
		send(enc_mem(OP_JMPF, 4'd0, 8'd0));
		send(enc_mem(OP_JMPT, 4'd0, 8'd0));
		send(enc_mem(OP_STORE, 4'd3, 8'd255));
		// Jump to the top of the address space, then let the increment wrap to zero.
		send(enc_mem(OP_JMP, 4'd0, 8'd255));
		send(enc_rrr(OP_NOP, 4'd0, 4'd0, 4'd0));
		send(enc_mem(OP_STORE, 4'd2, 8'd2));
		send(enc_mem(OP_LOAD, 4'd7, 8'd2));
		// Register indices past the file read as zero and drop their writes.
		send(enc_rrr(OP_ADD, 4'd0, 4'd1, 4'd15));
		send(enc_rrr(OP_SUB, 4'd12, 4'd0, 4'd5));
		send(enc_rrr(OP_CMP, 4'd13, 4'd14, 4'd0));
		send(enc_mem(OP_LOAD, 4'd10, 8'd0));
		send(enc_mem(OP_STORE, 4'd11, 8'd3));
		send({OP_RSV7, 12'hfff});
		send({OP_RSV63, 12'hfff});
		send(enc_mem(OP_JMP, 4'd15, 8'd200));

		while (sent_rand < RANDOM_ITEMS) begin
			if ($urandom_range(0, 79) == 0)
				quiet_tx = !quiet_tx;
			calm = (sent_rand >= RANDOM_ITEMS - CALM_TAIL);
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				send(enc_rrr(OP_CMP, gpr_pick(), gpr_pick(), 4'($urandom)));
				send(enc_mem($urandom_range(0, 1) ? OP_JMPT : OP_JMPF, 4'($urandom),
					addr_pick()));
				sent_rand += 2;
			end else if (pick == 1) begin
				// Store a register and jump through it, so register values become pcs.
				a = addr_pick();
				send(enc_mem(OP_STORE, gpr_pick(), a));
				send(enc_mem(OP_JMP, 4'($urandom), a));
				sent_rand += 2;
			end else begin
				send(rand_instr());
				sent_rand++;
			end
		end

		@(negedge clk);
		push <= 1'b0;
		while (outstanding != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Executed %0d instructions, the first 24 directed, and checked %0d results.",
			issued, checked);
		$display("%0d results reported a halted core and %0d jumps were taken.",
			halt_count, jumps_taken);
		if (mismatches == 0 && outstanding == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
